>>> hw/rtl/i2cmts_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// Defines the item structs, phase enum, command and status codes.
// No dependencies.
`default_nettype none

package i2cmts_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  dev_address;
    logic [15:0] tx_length;
    logic [15:0] rx_length;
    logic [7:0]  tx_byte;
    logic [7:0]  engine_status;
    logic [7:0]  received_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  write_byte;
    logic        byte_request;
    logic [15:0] tx_index;
    logic        rx_valid;
    logic [15:0] rx_index;
    logic [7:0]  rx_byte;
    logic        finished;
    logic [7:0]  result_status;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_ADDR_W,
    PH_DATA_REQ,
    PH_DATA_W,
    PH_RESTART,
    PH_ADDR_R,
    PH_READ_ACK,
    PH_READ_NACK
  } phase_t;

  // operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DONE  = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;

  // bus engine commands
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ_ACK  = 3'd3;
  localparam logic [2:0] CMD_READ_NACK = 3'd4;
  localparam logic [2:0] CMD_STOP      = 3'd5;

  localparam logic [7:0] STATUS_MASK = 8'hF8;
  localparam logic       READ_BIT    = 1'b1;

  // expected masked engine status per phase
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

endpackage

`default_nettype wire

>>> hw/rtl/i2cmts_in_if.sv
// Input channel interface: valid/ready handshake carrying in_item_t.
// Depends on i2cmts_pkg.
`default_nettype none

interface i2cmts_in_if
  import i2cmts_pkg::*;
  ;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/i2cmts_out_if.sv
// Result channel interface: valid/ready handshake carrying out_item_t.
// Depends on i2cmts_pkg.
`default_nettype none

interface i2cmts_out_if
  import i2cmts_pkg::*;
  ;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/i2cmts_step.sv
// Transaction state registers and single-pass next-state/result logic.
// One accepted item updates the phase and counters and yields one result.
// Depends on i2cmts_pkg.
`default_nettype none

module i2cmts_step
  import i2cmts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_item_t  item,
  output out_item_t      result
);

  phase_t      phase_r,   phase_nxt;
  logic [6:0]  target_r,  target_nxt;
  logic [15:0] wleft_r,   wleft_nxt;
  logic [15:0] rleft_r,   rleft_nxt;
  logic [15:0] wpos_r,    wpos_nxt;
  logic [15:0] rpos_r,    rpos_nxt;
  logic        restart_r, restart_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      target_r  <= '0;
      wleft_r   <= '0;
      rleft_r   <= '0;
      wpos_r    <= '0;
      rpos_r    <= '0;
      restart_r <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      target_r  <= target_nxt;
      wleft_r   <= wleft_nxt;
      rleft_r   <= rleft_nxt;
      wpos_r    <= wpos_nxt;
      rpos_r    <= rpos_nxt;
      restart_r <= restart_nxt;
    end
  end

  logic [7:0] st;
  logic [7:0] expect_st;
  logic       known;
  logic       do_after;
  logic       do_read;
  logic       do_req;

  always_comb begin
    phase_nxt   = phase_r;
    target_nxt  = target_r;
    wleft_nxt   = wleft_r;
    rleft_nxt   = rleft_r;
    wpos_nxt    = wpos_r;
    rpos_nxt    = rpos_r;
    restart_nxt = restart_r;
    result      = '0;
    st          = item.engine_status & STATUS_MASK;
    expect_st   = '0;
    known       = 1'b0;
    do_after    = 1'b0;
    do_read     = 1'b0;
    do_req      = 1'b0;

    case (item.operation)
      OP_BEGIN: begin
        if (phase_r == PH_IDLE) begin
          target_nxt     = item.dev_address;
          wleft_nxt      = item.tx_length;
          rleft_nxt      = item.rx_length;
          wpos_nxt       = '0;
          rpos_nxt       = '0;
          restart_nxt    = 1'b0;
          result.command = CMD_START;
          phase_nxt      = PH_START;
        end
      end
      OP_BYTE: begin
        if (phase_r == PH_DATA_REQ) begin
          result.command    = CMD_WRITE;
          result.write_byte = item.tx_byte;
          phase_nxt         = PH_DATA_W;
        end
      end
      OP_DONE: begin
        known = 1'b1;
        case (phase_r)
          PH_START:     expect_st = ST_START;
          PH_ADDR_W:    expect_st = ST_ADDR_W_ACK;
          PH_DATA_W:    expect_st = ST_DATA_W_ACK;
          PH_RESTART:   expect_st = ST_RESTART;
          PH_ADDR_R:    expect_st = ST_ADDR_R_ACK;
          PH_READ_ACK:  expect_st = ST_DATA_R_ACK;
          PH_READ_NACK: expect_st = ST_DATA_R_NACK;
          default:      known     = 1'b0;
        endcase

        if (known) begin
          // received byte is reported even if the status check fails
          if (phase_r == PH_READ_ACK || phase_r == PH_READ_NACK) begin
            result.rx_valid = 1'b1;
            result.rx_index = rpos_r;
            result.rx_byte  = item.received_byte;
          end

          if (st != expect_st) begin
            result.finished      = 1'b1;
            result.result_status = st;
            phase_nxt            = PH_IDLE;
          end else begin
            case (phase_r)
              PH_START: begin
                if (wleft_r != '0) begin
                  result.command    = CMD_WRITE;
                  result.write_byte = {target_r, 1'b0};
                  restart_nxt       = 1'b1;
                  phase_nxt         = PH_ADDR_W;
                end else begin
                  do_after = 1'b1;
                end
              end
              PH_ADDR_W: do_req = 1'b1;
              PH_DATA_W: begin
                wpos_nxt  = wpos_r + 16'd1;
                wleft_nxt = wleft_r - 16'd1;
                if (wleft_nxt != '0) do_req = 1'b1;
                else                 do_after = 1'b1;
              end
              PH_RESTART: begin
                result.command    = CMD_WRITE;
                result.write_byte = {target_r, READ_BIT};
                phase_nxt         = PH_ADDR_R;
              end
              PH_ADDR_R: do_read = 1'b1;
              PH_READ_ACK: begin
                rpos_nxt  = rpos_r + 16'd1;
                rleft_nxt = rleft_r - 16'd1;
                do_read   = 1'b1;
              end
              default: begin
                rpos_nxt             = rpos_r + 16'd1;
                rleft_nxt            = '0;
                result.command       = CMD_STOP;
                result.finished      = 1'b1;
                result.result_status = '0;
                phase_nxt            = PH_IDLE;
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    if (do_req) begin
      result.byte_request = 1'b1;
      result.tx_index     = wpos_nxt;
      phase_nxt           = PH_DATA_REQ;
    end

    if (do_after) begin
      if (rleft_r != '0) begin
        if (restart_r) begin
          result.command = CMD_START;
          phase_nxt      = PH_RESTART;
        end else begin
          result.command    = CMD_WRITE;
          result.write_byte = {target_r, READ_BIT};
          phase_nxt         = PH_ADDR_R;
        end
      end else begin
        result.command       = CMD_STOP;
        result.finished      = 1'b1;
        result.result_status = '0;
        phase_nxt            = PH_IDLE;
      end
    end

    if (do_read) begin
      if (rleft_nxt > 16'd1) begin
        result.command = CMD_READ_ACK;
        phase_nxt      = PH_READ_ACK;
      end else begin
        result.command = CMD_READ_NACK;
        phase_nxt      = PH_READ_NACK;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/i2cmts_out_reg.sv
// Result register: holds one result until the downstream side takes it.
// Space is offered whenever the register is empty or being drained.
// Depends on i2cmts_pkg.
`default_nettype none

module i2cmts_out_reg
  import i2cmts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_item_t load_data,
  output logic           space,
  output logic           valid,
  input  wire logic      ready,
  output out_item_t      data
);

  logic      valid_r;
  out_item_t data_r;

  assign space = !valid_r || ready;
  assign valid = valid_r;
  assign data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer, top level.
//
// in_if carries host and bus engine events: begin a transaction (address,
// write and read lengths), engine step completed (status and read byte),
// or a write data byte previously requested by index. Every accepted
// transaction on in_if produces exactly one result on out_if: the next
// engine command with its byte, a write data request, a received byte,
// and the finished flag with the final status.
//
// The result of a transaction accepted at one edge is valid on out_if
// after that edge. Throughput is one transaction per cycle while out_if
// takes results, set by the single-pass phase logic feeding the register.
//
// Reset (rst_n low, synchronous) returns the sequencer to idle with all
// counters cleared and empties the result register.
// When out_if stalls, in_if.ready drops once the result register is full;
// a held result is kept unchanged until taken.
// Depends on i2cmts_pkg, i2cmts_in_if, i2cmts_out_if, i2cmts_step and
// i2cmts_out_reg.
`default_nettype none

module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  i2cmts_in_if.sink    in_if,
  i2cmts_out_if.source out_if
);

  logic      space;
  logic      fire;
  out_item_t step_result;

  assign in_if.ready = space;
  assign fire        = in_if.valid && space;

  i2cmts_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_if.data),
    .result (step_result)
  );

  i2cmts_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_data (step_result),
    .space     (space),
    .valid     (out_if.valid),
    .ready     (out_if.ready),
    .data      (out_if.data)
  );

endmodule

`default_nettype wire

>>> tb/sv/i2c_master_transfer_sequencer_tb.sv
// Testbench for the I2C master transfer sequencer: directed and random bus
// transactions with idle gaps on both channels, checked against a local model.
// Depends on i2cmts_pkg, i2cmts_in_if, i2cmts_out_if and the sequencer RTL.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_tb
  import i2cmts_pkg::*;
  ;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         ITEMS_TARGET = 950;
  localparam int         MAX_PRINTED  = 30;

  logic clk = 1'b0;
  logic rst_n;

  i2cmts_in_if  in_ch();
  i2cmts_out_if out_ch();

  i2c_master_transfer_sequencer DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

  // sequencer model state
  phase_t      seq_phase       = PH_IDLE;
  logic [6:0]  tgt_addr        = '0;
  logic [15:0] writes_due      = '0;
  logic [15:0] reads_due       = '0;
  logic [15:0] write_idx       = '0;
  logic [15:0] read_idx        = '0;
  logic        restart_pending = 1'b0;

  out_item_t bus_actions_due[$];
  int        mismatch_count   = 0;
  int        items_sent       = 0;
  bit        sender_eager     = 1'b0;
  bit        force_zero_abort = 1'b0;
  int        sink_hold_req    = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  function automatic void end_ok(inout out_item_t r);
    r.command       = CMD_STOP;
    r.finished      = 1'b1;
    r.result_status = '0;
    seq_phase       = PH_IDLE;
  endfunction

  function automatic void issue_read(inout out_item_t r);
    r.command = (reads_due > 1) ? CMD_READ_ACK : CMD_READ_NACK;
    seq_phase = (reads_due > 1) ? PH_READ_ACK : PH_READ_NACK;
  endfunction

  function automatic void request_byte(inout out_item_t r);
    r.byte_request = 1'b1;
    r.tx_index     = write_idx;
    seq_phase      = PH_DATA_REQ;
  endfunction

  // all writes done (or none): repeated start, address+read, or stop
  function automatic void close_writes(inout out_item_t r);
    if (reads_due != 0) begin
      if (restart_pending) begin
        r.command = CMD_START;
        seq_phase = PH_RESTART;
      end else begin
        r.command    = CMD_WRITE;
        r.write_byte = {tgt_addr, READ_BIT};
        seq_phase    = PH_ADDR_R;
      end
    end else begin
      end_ok(r);
    end
  endfunction

  function automatic out_item_t next_bus_action(input in_item_t it);
    out_item_t   r;
    logic [7:0]  st;
    logic [7:0]  code;
    r    = '0;
    st   = it.engine_status & STATUS_MASK;
    code = '0;
    case (it.operation)
      OP_BEGIN: begin
        if (seq_phase == PH_IDLE) begin
          tgt_addr        = it.dev_address;
          writes_due      = it.tx_length;
          reads_due       = it.rx_length;
          write_idx       = '0;
          read_idx        = '0;
          restart_pending = 1'b0;
          r.command       = CMD_START;
          seq_phase       = PH_START;
        end
      end
      OP_BYTE: begin
        if (seq_phase == PH_DATA_REQ) begin
          r.command    = CMD_WRITE;
          r.write_byte = it.tx_byte;
          seq_phase    = PH_DATA_W;
        end
      end
      OP_DONE: begin
        case (seq_phase)
          PH_START:     code = ST_START;
          PH_ADDR_W:    code = ST_ADDR_W_ACK;
          PH_DATA_W:    code = ST_DATA_W_ACK;
          PH_RESTART:   code = ST_RESTART;
          PH_ADDR_R:    code = ST_ADDR_R_ACK;
          PH_READ_ACK:  code = ST_DATA_R_ACK;
          PH_READ_NACK: code = ST_DATA_R_NACK;
          default:      code = '0;
        endcase
        if (code != '0) begin
          // read byte is reported even when the status check fails
          if (seq_phase == PH_READ_ACK || seq_phase == PH_READ_NACK) begin
            r.rx_valid = 1'b1;
            r.rx_index = read_idx;
            r.rx_byte  = it.received_byte;
          end
          if (st != code) begin
            r.finished      = 1'b1;
            r.result_status = st;
            seq_phase       = PH_IDLE;
          end else begin
            case (seq_phase)
              PH_START: begin
                if (writes_due != 0) begin
                  r.command       = CMD_WRITE;
                  r.write_byte    = {tgt_addr, 1'b0};
                  restart_pending = 1'b1;
                  seq_phase       = PH_ADDR_W;
                end else begin
                  close_writes(r);
                end
              end
              PH_ADDR_W: request_byte(r);
              PH_DATA_W: begin
                write_idx  = write_idx + 16'd1;
                writes_due = writes_due - 16'd1;
                if (writes_due != 0) request_byte(r);
                else close_writes(r);
              end
              PH_RESTART: begin
                r.command    = CMD_WRITE;
                r.write_byte = {tgt_addr, READ_BIT};
                seq_phase    = PH_ADDR_R;
              end
              PH_ADDR_R: issue_read(r);
              PH_READ_ACK: begin
                read_idx  = read_idx + 16'd1;
                reads_due = reads_due - 16'd1;
                issue_read(r);
              end
              default: begin
                read_idx  = read_idx + 16'd1;
                reads_due = '0;
                end_ok(r);
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checking; the model is advanced on every accepted input transaction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (bus_actions_due.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = bus_actions_due.pop_front();
          check_field("command", 16'(out_ch.data.command), 16'(want.command));
          check_field("write_byte", 16'(out_ch.data.write_byte), 16'(want.write_byte));
          check_field("byte_request", 16'(out_ch.data.byte_request),
                      16'(want.byte_request));
          check_field("tx_index", out_ch.data.tx_index, want.tx_index);
          check_field("rx_valid", 16'(out_ch.data.rx_valid), 16'(want.rx_valid));
          check_field("rx_index", out_ch.data.rx_index, want.rx_index);
          check_field("rx_byte", 16'(out_ch.data.rx_byte), 16'(want.rx_byte));
          check_field("finished", 16'(out_ch.data.finished), 16'(want.finished));
          check_field("result_status", 16'(out_ch.data.result_status),
                      16'(want.result_status));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        bus_actions_due.push_back(next_bus_action(in_ch.data));
    end
  end

  // mostly short idles, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req > 0) begin
        hold          = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        hold = idle_length();
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic in_item_t random_item(input logic [1:0] op);
    in_item_t it;
    it.operation     = op;
    it.dev_address   = 7'($urandom);
    it.tx_length     = 16'($urandom);
    it.rx_length     = 16'($urandom);
    it.tx_byte       = 8'($urandom);
    it.engine_status = 8'($urandom);
    it.received_byte = 8'($urandom);
    return it;
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input in_item_t it, input bit counted);
    int gap;
    gap = sender_eager ? 0 : idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (counted) items_sent++;
  endtask

  // an item the sequencer must ignore in the given phase
  task automatic send_noise(input phase_t at);
    logic [1:0] op;
    bit         ok;
    do begin
      op = 2'($urandom_range(0, 3));
      ok = (op == OP_UNUSED) ||
           (op == OP_BEGIN && at != PH_IDLE) ||
           (op == OP_DONE && (at == PH_IDLE || at == PH_DATA_REQ)) ||
           (op == OP_BYTE && at != PH_DATA_REQ);
    end while (!ok);
    send_item(random_item(op), 1'b0);
  endtask

  // engine completion; fails the step when the countdown reaches zero
  task automatic engine_done(input logic [7:0] code, inout int fail_in, output bit aborted);
    in_item_t it;
    it      = random_item(OP_DONE);
    aborted = (fail_in == 0);
    if (aborted) begin
      if (force_zero_abort || $urandom_range(0, 3) == 0)
        it.engine_status = 8'($urandom_range(0, 7));
      else
        do it.engine_status = 8'($urandom); while ((it.engine_status & STATUS_MASK) == code);
    end else begin
      it.engine_status = code | 8'($urandom_range(0, 7));
    end
    fail_in--;
    send_item(it, 1'b1);
  endtask

  // one bus transaction as a well-behaved engine and host would drive it
  task automatic run_transfer(input logic [6:0] addr, input logic [15:0] n_wr,
                              input logic [15:0] n_rd, input int fail_in, input bit noisy);
    in_item_t it;
    bit       aborted;
    int       left;
    left             = fail_in;
    it               = random_item(OP_BEGIN);
    it.dev_address   = addr;
    it.tx_length     = n_wr;
    it.rx_length     = n_rd;
    send_item(it, 1'b1);
    if (noisy) send_noise(PH_START);
    engine_done(ST_START, left, aborted);
    if (aborted) return;
    if (n_wr != 0) begin
      engine_done(ST_ADDR_W_ACK, left, aborted);
      if (aborted) return;
      for (int i = 0; i < n_wr; i++) begin
        if (noisy && $urandom_range(0, 2) == 0) send_noise(PH_DATA_REQ);
        send_item(random_item(OP_BYTE), 1'b1);
        engine_done(ST_DATA_W_ACK, left, aborted);
        if (aborted) return;
      end
    end
    if (n_rd != 0) begin
      if (n_wr != 0) begin
        engine_done(ST_RESTART, left, aborted);
        if (aborted) return;
      end
      engine_done(ST_ADDR_R_ACK, left, aborted);
      if (aborted) return;
      for (int i = 0; i < n_rd; i++) begin
        engine_done((i == n_rd - 1) ? ST_DATA_R_NACK : ST_DATA_R_ACK, left, aborted);
        if (aborted) return;
      end
    end
  endtask

  task automatic test_directed_flows();
    run_transfer(7'h00, 16'd0, 16'd0, -1, 1'b0);   // empty transaction: start then stop
    run_transfer(7'h7F, 16'd1, 16'd2, -1, 1'b0);   // write, repeated start, two reads
  endtask

  task automatic test_directed_errors();
    // full-scale lengths, address+write refused with a masked status of zero
    force_zero_abort = 1'b1;
    run_transfer(7'h55, 16'hFFFF, 16'hFFFF, 1, 1'b0);
    force_zero_abort = 1'b0;
    // read-only, first data read fails: byte still reported
    run_transfer(7'h2A, 16'd0, 16'h8000, 2, 1'b0);
    repeat (3) send_noise(PH_IDLE);
    run_transfer(7'h33, 16'd1, 16'd0, -1, 1'b1);
  endtask

  task automatic test_result_backpressure();
    sink_hold_req = 80;
    sender_eager  = 1'b1;
    run_transfer(7'h12, 16'd3, 16'd3, -1, 1'b0);
    sender_eager  = 1'b0;
  endtask

  task automatic test_random_transfers();
    logic [15:0] n_wr;
    logic [15:0] n_rd;
    int          fail_in;
    while (items_sent < ITEMS_TARGET) begin
      sender_eager = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 29) == 0) begin
        // long lengths: abort early so the run stays short
        n_wr    = 16'($urandom);
        n_rd    = 16'($urandom);
        fail_in = $urandom_range(0, 6);
      end else begin
        n_wr    = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        n_rd    = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        fail_in = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * n_wr + n_rd + 3) : -1;
      end
      if ($urandom_range(0, 5) == 0) send_noise(PH_IDLE);
      run_transfer(7'($urandom), n_wr, n_rd, fail_in, $urandom_range(0, 3) == 0);
    end
    sender_eager = 1'b0;
  endtask

  initial begin : main_sequence
    int drain_cycles;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    drain_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_flows();
    test_directed_errors();
    test_result_backpressure();
    test_random_transfers();

    in_ch.valid <= 1'b0;
    while (bus_actions_due.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (bus_actions_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", bus_actions_due.size()));

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
